// File: hw/rtl/bilinear_wrap_texture_sampler_defines.svh
// Assertion macros shared by the sampler's checker.
`ifndef BILINEAR_WRAP_TEXTURE_SAMPLER_DEFINES_SVH
`define BILINEAR_WRAP_TEXTURE_SAMPLER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BWTS_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BWTS_ASSERT_NXT(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/bwts_pkg.sv
// Shared types, constants and address helpers of the bilinear sampler.
package bwts_pkg;

	localparam int COORD_W     = 32;
	localparam int CH_W        = 16;
	localparam int TEXEL_AW    = 16;
	localparam int TEXEL_DEPTH = 1 << TEXEL_AW;
	localparam int SIZE_W      = 9;
	localparam int MAX_WIDTH   = 256;
	localparam int MAX_HEIGHT  = 256;
	localparam int P_W         = SIZE_W + 17;   // signed n*size - 0.5
	localparam int FRAC_W      = 18;            // signed fraction and 1-f
	localparam int L_W         = 36;            // row blend, scale 2^16
	localparam int T_W         = 56;            // column blend, scale 2^32
	localparam int FIFO_DEPTH  = 16;
	localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
	localparam int CNT_W       = FIFO_AW + 1;

	localparam int CFG_IDX_W   = 2;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TEXTURE_PRESENT = 2'd2;

	localparam logic CMD_SAMPLE = 1'b0;
	localparam logic CMD_LOAD   = 1'b1;

	typedef struct packed {
		logic [CH_W-1:0] r;
		logic [CH_W-1:0] g;
		logic [CH_W-1:0] b;
	} texel_t;

	typedef logic [2:0][CH_W-1:0] chan_vec_t;

	typedef struct packed {
		logic valid;
		logic load;
		logic zero;
	} ctrl_t;

	typedef struct packed {
		logic [SIZE_W-1:0]        i0;
		logic [SIZE_W-1:0]        i1;
		logic signed [FRAC_W-1:0] frac;
	} loc_t;

	// Zero is taken as one, anything past the maximum as the maximum.
	function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] v, input int maxv);
		logic [SIZE_W-1:0] r;
		if (v == '0) r = SIZE_W'(1);
		else if (int'(v) > maxv) r = SIZE_W'(maxv);
		else r = v;
		return r;
	endfunction

	// Base texel, clamped neighbor and signed fraction from p = n*size - 0.5.
	function automatic loc_t locate(input logic signed [P_W-1:0] p, input logic [SIZE_W-1:0] size);
		loc_t              r;
		logic [SIZE_W-1:0] base;
		logic [SIZE_W-1:0] smax;
		logic [SIZE_W:0]   nxt;
		smax = size - SIZE_W'(1);
		if (p < 0) begin
			// low edge: base 0, negative fraction extrapolates
			base   = '0;
			r.frac = p[FRAC_W-1:0];
		end else begin
			base   = p[SIZE_W+15:16];
			r.frac = {2'b00, p[15:0]};
		end
		if (base > smax) base = smax;
		nxt  = {1'b0, base} + (SIZE_W+1)'(1);
		r.i0 = base;
		r.i1 = (nxt > {1'b0, smax}) ? smax : nxt[SIZE_W-1:0];
		return r;
	endfunction

endpackage

// File: hw/rtl/bwts_if.sv
// Request and result channel interfaces of the bilinear sampler.
interface bwts_in_if import bwts_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic                      cmd;
	logic signed [COORD_W-1:0] u_coord;
	logic signed [COORD_W-1:0] v_coord;
	logic [TEXEL_AW-1:0]       texel_index;
	logic [CH_W-1:0]           load_red;
	logic [CH_W-1:0]           load_green;
	logic [CH_W-1:0]           load_blue;

	modport source (output valid, cmd, u_coord, v_coord, texel_index,
		load_red, load_green, load_blue, input ready);
	modport sink (input valid, cmd, u_coord, v_coord, texel_index,
		load_red, load_green, load_blue, output ready);
endinterface

interface bwts_out_if import bwts_pkg::*; ();
	logic            valid;
	logic            ready;
	logic [CH_W-1:0] sample_red;
	logic [CH_W-1:0] sample_green;
	logic [CH_W-1:0] sample_blue;

	modport source (output valid, sample_red, sample_green, sample_blue, input ready);
	modport sink (input valid, sample_red, sample_green, sample_blue, output ready);
endinterface

// File: hw/rtl/bilinear_wrap_texture_sampler.sv
// Top level of the bilinear wrap-addressing texture sampler.
//
//  channel  dir  handshake        carries
//  in_ch    in   valid / ready    cmd, u_coord, v_coord, texel_index, load rgb
//  out_ch   out  valid / ready    sample_red, sample_green, sample_blue
//  wr_*     in   wr_en only       register index and 9-bit data
//
// One request per cycle while in_ch.ready is high. Samples pass stage 1,
// stage 2 and blend stages s3 to s6 into the result queue; loads write the
// store from stage 2, in request order, so a later sample always sees them.
// The store is two copies with two read ports each, giving the four texel
// reads per cycle. in_ch.ready drops while 16 samples are outstanding (queue
// depth). Reset clears control only; the store has no clearing pass.
module bilinear_wrap_texture_sampler import bwts_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	bwts_in_if.sink              in_ch,
	bwts_out_if.source           out_ch,
	input  logic                 wr_en,
	input  logic [CFG_IDX_W-1:0] wr_index,
	input  logic [SIZE_W-1:0]    wr_data
);

	logic [SIZE_W-1:0]        width_q, height_q;
	logic                     present_q;
	logic [SIZE_W-1:0]        w_eff, h_eff;
	logic [CNT_W-1:0]         pend_q;
	logic                     in_acc, smp_acc, out_acc;
	ctrl_t                    ctrl_s2;
	logic [TEXEL_AW-1:0]      addr00, addr10, addr01, addr11, widx_s2;
	texel_t                   texel_in, texel_s2;
	logic signed [FRAC_W-1:0] fx_s2, fy_s2;
	texel_t                   t00, t10, t01, t11;
	logic                     mem_we, mem_re;
	logic                     push, not_empty;
	texel_t                   result, head;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q   <= SIZE_W'(1);
			height_q  <= SIZE_W'(1);
			present_q <= 1'b0;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_IMAGE_WIDTH:     width_q   <= wr_data;
				REG_IMAGE_HEIGHT:    height_q  <= wr_data;
				REG_TEXTURE_PRESENT: present_q <= wr_data[0];
				default: ;
			endcase
		end
	end

	assign w_eff = eff_size(width_q, MAX_WIDTH);
	assign h_eff = eff_size(height_q, MAX_HEIGHT);

	// credit count: samples taken and not yet delivered
	assign in_acc  = in_ch.valid && in_ch.ready;
	assign smp_acc = in_acc && (in_ch.cmd == CMD_SAMPLE);
	assign out_acc = out_ch.valid && out_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) pend_q <= '0;
		else pend_q <= pend_q + CNT_W'(smp_acc) - CNT_W'(out_acc);
	end

	assign in_ch.ready = (pend_q < CNT_W'(FIFO_DEPTH));
	assign texel_in    = '{r: in_ch.load_red, g: in_ch.load_green, b: in_ch.load_blue};

	bwts_addr u_addr (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_acc      (in_acc),
		.in_cmd      (in_ch.cmd),
		.u_lo        (in_ch.u_coord[15:0]),
		.v_lo        (in_ch.v_coord[15:0]),
		.texel_index (in_ch.texel_index),
		.texel_in    (texel_in),
		.width       (w_eff),
		.height      (h_eff),
		.present     (present_q),
		.ctrl_s2     (ctrl_s2),
		.addr00      (addr00),
		.addr10      (addr10),
		.addr01      (addr01),
		.addr11      (addr11),
		.widx_s2     (widx_s2),
		.texel_s2    (texel_s2),
		.fx_s2       (fx_s2),
		.fy_s2       (fy_s2)
	);

	// both copies take every load; reads only for samples
	assign mem_we = ctrl_s2.valid && ctrl_s2.load;
	assign mem_re = ctrl_s2.valid && !ctrl_s2.load;

	bwts_mem u_mem_row0 (
		.clk    (clk),
		.we     (mem_we),
		.waddr  (widx_s2),
		.wdata  (texel_s2),
		.re     (mem_re),
		.raddr0 (addr00),
		.raddr1 (addr10),
		.rdata0 (t00),
		.rdata1 (t10)
	);

	bwts_mem u_mem_row1 (
		.clk    (clk),
		.we     (mem_we),
		.waddr  (widx_s2),
		.wdata  (texel_s2),
		.re     (mem_re),
		.raddr0 (addr01),
		.raddr1 (addr11),
		.rdata0 (t01),
		.rdata1 (t11)
	);

	bwts_blend u_blend (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl_s2 (ctrl_s2),
		.fx_s2   (fx_s2),
		.fy_s2   (fy_s2),
		.t00     (t00),
		.t10     (t10),
		.t01     (t01),
		.t11     (t11),
		.push    (push),
		.result  (result)
	);

	bwts_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.din       (result),
		.pop       (out_acc),
		.not_empty (not_empty),
		.dout      (head)
	);

	assign out_ch.valid        = not_empty;
	assign out_ch.sample_red   = head.r;
	assign out_ch.sample_green = head.g;
	assign out_ch.sample_blue  = head.b;

endmodule

// File: hw/rtl/bwts_mem.sv
// Texel store copy: one write port, two registered read ports.
module bwts_mem import bwts_pkg::*; (
	input  logic                clk,
	input  logic                we,
	input  logic [TEXEL_AW-1:0] waddr,
	input  texel_t              wdata,
	input  logic                re,
	input  logic [TEXEL_AW-1:0] raddr0,
	input  logic [TEXEL_AW-1:0] raddr1,
	output texel_t              rdata0,
	output texel_t              rdata1
);

	texel_t mem_q [TEXEL_DEPTH];
	texel_t rd0_q;
	texel_t rd1_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
	end

	// read ports, registered
	always_ff @(posedge clk) begin
		if (re) begin
			rd0_q <= mem_q[raddr0];
			rd1_q <= mem_q[raddr1];
		end
	end

	assign rdata0 = rd0_q;
	assign rdata1 = rd1_q;

endmodule

// File: hw/rtl/bwts_addr.sv
// Coordinate wrap, scale, edge clamp and texel address generation.
module bwts_addr import bwts_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_acc,
	input  logic                     in_cmd,
	input  logic [15:0]              u_lo,
	input  logic [15:0]              v_lo,
	input  logic [TEXEL_AW-1:0]      texel_index,
	input  texel_t                   texel_in,
	input  logic [SIZE_W-1:0]        width,
	input  logic [SIZE_W-1:0]        height,
	input  logic                     present,
	output ctrl_t                    ctrl_s2,
	output logic [TEXEL_AW-1:0]      addr00,
	output logic [TEXEL_AW-1:0]      addr10,
	output logic [TEXEL_AW-1:0]      addr01,
	output logic [TEXEL_AW-1:0]      addr11,
	output logic [TEXEL_AW-1:0]      widx_s2,
	output texel_t                   texel_s2,
	output logic signed [FRAC_W-1:0] fx_s2,
	output logic signed [FRAC_W-1:0] fy_s2
);

	localparam int PROD_W = 16 + SIZE_W;
	localparam int ROW_W  = 2 * SIZE_W;

	logic [PROD_W-1:0]       u_prod, v_prod;
	logic signed [P_W-1:0]   px_d, py_d;
	ctrl_t                   ctrl_s1;
	logic signed [P_W-1:0]   px_s1, py_s1;
	logic [TEXEL_AW-1:0]     idx_s1;
	texel_t                  texel_s1;
	loc_t                    locx, locy;
	logic [SIZE_W-1:0]       x0_s2, x1_s2;
	logic [ROW_W-1:0]        y0w_s2, y1w_s2;
	logic [ROW_W-1:0]        s00, s10, s01, s11;

	// scale wrapped coordinate by image size, minus half a texel
	assign u_prod = PROD_W'(u_lo) * PROD_W'(width);
	assign v_prod = PROD_W'(v_lo) * PROD_W'(height);
	assign px_d   = $signed({1'b0, u_prod}) - P_W'(32768);
	assign py_d   = $signed({1'b0, v_prod}) - P_W'(32768);

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
		end else begin
			ctrl_s1.valid <= in_acc;
			ctrl_s1.load  <= (in_cmd == CMD_LOAD);
			ctrl_s1.zero  <= !present;
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		px_s1    <= px_d;
		py_s1    <= py_d;
		idx_s1   <= texel_index;
		texel_s1 <= texel_in;
	end

	assign locx = locate(px_s1, width);
	assign locy = locate(py_s1, height);

	// stage 2 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ctrl_s2 <= '0;
		else ctrl_s2 <= ctrl_s1;
	end

	// stage 2 payload: row offsets y*width
	always_ff @(posedge clk) begin
		x0_s2    <= locx.i0;
		x1_s2    <= locx.i1;
		y0w_s2   <= ROW_W'(locy.i0) * ROW_W'(width);
		y1w_s2   <= ROW_W'(locy.i1) * ROW_W'(width);
		fx_s2    <= locx.frac;
		fy_s2    <= locy.frac;
		widx_s2  <= idx_s1;
		texel_s2 <= texel_s1;
	end

	// store addresses wrap to the address width
	assign s00    = ROW_W'(x0_s2) + y0w_s2;
	assign s10    = ROW_W'(x1_s2) + y0w_s2;
	assign s01    = ROW_W'(x0_s2) + y1w_s2;
	assign s11    = ROW_W'(x1_s2) + y1w_s2;
	assign addr00 = s00[TEXEL_AW-1:0];
	assign addr10 = s10[TEXEL_AW-1:0];
	assign addr01 = s01[TEXEL_AW-1:0];
	assign addr11 = s11[TEXEL_AW-1:0];

endmodule

// File: hw/rtl/bwts_blend.sv
// Bilinear blend of four texels: row pass, column pass, round, saturate.
module bwts_blend import bwts_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  ctrl_t                    ctrl_s2,
	input  logic signed [FRAC_W-1:0] fx_s2,
	input  logic signed [FRAC_W-1:0] fy_s2,
	input  texel_t                   t00,
	input  texel_t                   t10,
	input  texel_t                   t01,
	input  texel_t                   t11,
	output logic                     push,
	output texel_t                   result
);

	localparam logic signed [FRAC_W-1:0] ONE_Q16 = FRAC_W'(65536);

	logic                     v_s3, v_s4, v_s5, v_s6;
	logic                     zero_s3, zero_s4, zero_s5, zero_s6;
	logic signed [FRAC_W-1:0] fx_s3, fy_s3, fy_s4;
	logic signed [FRAC_W-1:0] omfx, omfy;
	chan_vec_t                c00, c10, c01, c11;
	chan_vec_t                res_vec;

	// sample control down the blend pipe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			v_s3 <= ctrl_s2.valid && !ctrl_s2.load;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		zero_s3 <= ctrl_s2.zero;
		zero_s4 <= zero_s3;
		zero_s5 <= zero_s4;
		zero_s6 <= zero_s5;
		fx_s3   <= fx_s2;
		fy_s3   <= fy_s2;
		fy_s4   <= fy_s3;
	end

	assign omfx = ONE_Q16 - fx_s3;
	assign omfy = ONE_Q16 - fy_s4;
	assign c00  = chan_vec_t'(t00);
	assign c10  = chan_vec_t'(t10);
	assign c01  = chan_vec_t'(t01);
	assign c11  = chan_vec_t'(t11);

	for (genvar c = 0; c < 3; c++) begin : g_ch
		logic signed [L_W-1:0] a00, a10, a01, a11, fxl, omfxl;
		logic signed [L_W-1:0] l0_s4, l1_s4;
		logic signed [T_W-1:0] l0x, l1x, fyl, omfyl;
		logic signed [T_W-1:0] m0_s5, m1_s5, t_s6, t_rnd;
		logic [T_W-33:0]       r_hi;

		assign a00   = $signed({{(L_W-CH_W){1'b0}}, c00[c]});
		assign a10   = $signed({{(L_W-CH_W){1'b0}}, c10[c]});
		assign a01   = $signed({{(L_W-CH_W){1'b0}}, c01[c]});
		assign a11   = $signed({{(L_W-CH_W){1'b0}}, c11[c]});
		assign fxl   = L_W'(fx_s3);
		assign omfxl = L_W'(omfx);

		// row pass, scale 2^16
		always_ff @(posedge clk) begin
			l0_s4 <= a00 * omfxl + a10 * fxl;
			l1_s4 <= a01 * omfxl + a11 * fxl;
		end

		assign l0x   = T_W'(l0_s4);
		assign l1x   = T_W'(l1_s4);
		assign fyl   = T_W'(fy_s4);
		assign omfyl = T_W'(omfy);

		// column pass products
		always_ff @(posedge clk) begin
			m0_s5 <= l0x * omfyl;
			m1_s5 <= l1x * fyl;
		end

		always_ff @(posedge clk) begin
			t_s6 <= m0_s5 + m1_s5;
		end

		// round half up at 2^32, clip to unorm
		assign t_rnd = t_s6 + T_W'(64'h8000_0000);
		assign r_hi  = t_rnd[T_W-1:32];
		always_comb begin
			if (zero_s6 || t_s6 <= 0) res_vec[c] = '0;
			else if (r_hi > (T_W-32)'(16'hFFFF)) res_vec[c] = '1;
			else res_vec[c] = r_hi[CH_W-1:0];
		end
	end

	assign push   = v_s6;
	assign result = texel_t'(res_vec);

endmodule

// File: hw/rtl/bwts_fifo.sv
// Result queue between the blend pipe and the output channel.
module bwts_fifo import bwts_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  texel_t din,
	input  logic   pop,
	output logic   not_empty,
	output texel_t dout
);

	texel_t             fifo_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + FIFO_AW'(1);
			if (pop) rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
			count_q <= count_q + CNT_W'(push) - CNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) fifo_q[wr_ptr_q] <= din;
	end

	assign not_empty = (count_q != '0);
	assign dout      = fifo_q[rd_ptr_q];

endmodule

// File: hw/rtl/bwts_checker.sv
// Port-level checker of the sampler and its bind to the top level.
`include "bilinear_wrap_texture_sampler_defines.svh"

module bwts_checker import bwts_pkg::*; (
	input logic            clk,
	input logic            arst_n,
	input logic            in_valid,
	input logic            in_ready,
	input logic            in_cmd,
	input logic            out_valid,
	input logic            out_ready,
	input logic [CH_W-1:0] out_red,
	input logic [CH_W-1:0] out_green,
	input logic [CH_W-1:0] out_blue
);

	logic [CNT_W:0] owed_q;
	logic           smp, dlv;

	// samples taken minus results delivered
	assign smp = in_valid && in_ready && (in_cmd == CMD_SAMPLE);
	assign dlv = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) owed_q <= '0;
		else owed_q <= owed_q + (CNT_W+1)'(smp) - (CNT_W+1)'(dlv);
	end

	`BWTS_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid, "result dropped while stalled")
	`BWTS_ASSERT_NXT(a_out_stable, clk, arst_n, out_valid && !out_ready, $stable(out_red) && $stable(out_green) && $stable(out_blue), "result changed while stalled")
	`BWTS_ASSERT_IMP(a_no_extra, clk, arst_n, out_valid, owed_q != '0, "result with no sample owed")
	`BWTS_ASSERT_IMP(a_credit, clk, arst_n, owed_q >= (CNT_W+1)'(FIFO_DEPTH), !in_ready, "request taken past queue depth")

endmodule

bind bilinear_wrap_texture_sampler bwts_checker u_bwts_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.in_cmd    (in_ch.cmd),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_red   (out_ch.sample_red),
	.out_green (out_ch.sample_green),
	.out_blue  (out_ch.sample_blue)
);

// File: dv/tb_bilinear_wrap_texture_sampler.sv
// Self-checking testbench of the bilinear wrap-addressing texture sampler.
`timescale 1ns / 1ps

module tb_bilinear_wrap_texture_sampler;
	import bwts_pkg::*;

	localparam int CYCLE_LIMIT  = 3000000;
	localparam int SETTLE_TICKS = 12;

	typedef struct {
		logic [CH_W-1:0] r;
		logic [CH_W-1:0] g;
		logic [CH_W-1:0] b;
	} rgb_t;

	logic clk;
	logic arst_n;
	logic wr_en;
	logic [CFG_IDX_W-1:0] wr_index;
	logic [SIZE_W-1:0] wr_data;

	bwts_in_if in_ch();
	bwts_out_if out_ch();

	bilinear_wrap_texture_sampler dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data)
	);

	// shadow of the texel store and registers
	texel_t texels [0:TEXEL_DEPTH-1];
	bit written [0:TEXEL_DEPTH-1];
	logic [SIZE_W-1:0] width_reg;
	logic [SIZE_W-1:0] height_reg;
	logic present_reg;

	rgb_t pending_samples[$];
	int send_idle_pct;
	int recv_idle_pct;
	int hold_left;
	int cycles;
	int mismatches;
	int samples_sent;
	int loads_sent;
	int results_seen;
	int settings_used;

	// clock
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycles);
			$display("Simulation FAILED");
			$finish;
		end
	end

	// result side: random stalls, or a long hold-off when asked
	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_ch.ready <= 1'b0;
			hold_left = hold_left - 1;
		end else begin
			out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// compare each result with the oldest expected sample
	always @(posedge clk) begin
		rgb_t exp_rgb;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			results_seen++;
			if (pending_samples.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected result r=%h g=%h b=%h", out_ch.sample_red,
						out_ch.sample_green, out_ch.sample_blue);
			end else begin
				exp_rgb = pending_samples.pop_front();
				if (out_ch.sample_red !== exp_rgb.r || out_ch.sample_green !== exp_rgb.g ||
					out_ch.sample_blue !== exp_rgb.b) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Mismatch at %0t: expected r=%h g=%h b=%h, got r=%h g=%h b=%h",
							$realtime, exp_rgb.r, exp_rgb.g, exp_rgb.b, out_ch.sample_red,
							out_ch.sample_green, out_ch.sample_blue);
				end
			end
		end
	end

	function automatic int clamp_size(input logic [SIZE_W-1:0] v, input int maxv);
		if (v == 0) return 1;
		if (int'(v) > maxv) return maxv;
		return int'(v);
	endfunction

	// wrap, scale by size, minus half a texel; base, neighbor and signed fraction
	function automatic void wrap_axis(input logic [COORD_W-1:0] c, input int size,
		output int i0, output int i1, output longint f);
		longint p;
		int base;
		p = longint'(c[15:0]) * size - 32768;
		if (p < 0) begin
			base = 0;
			f = p;
		end else begin
			base = int'(p >>> 16);
			f = p & 64'hFFFF;
		end
		if (base > size - 1) base = size - 1;
		i0 = base;
		i1 = (base + 1 > size - 1) ? size - 1 : base + 1;
	endfunction

	function automatic logic [CH_W-1:0] blend_channel(input logic [CH_W-1:0] p00,
		input logic [CH_W-1:0] p10, input logic [CH_W-1:0] p01, input logic [CH_W-1:0] p11,
		input longint fx, input longint fy);
		longint l0;
		longint l1;
		longint t;
		longint r;
		l0 = longint'(p00) * (65536 - fx) + longint'(p10) * fx;
		l1 = longint'(p01) * (65536 - fx) + longint'(p11) * fx;
		t = l0 * (65536 - fy) + l1 * fy;
		if (t <= 0) return '0;
		r = (t + 64'h80000000) >>> 32;
		return (r > 65535) ? 16'hFFFF : CH_W'(r);
	endfunction

	// the four store addresses a sample at u,v reads
	function automatic void texel_addrs(input logic [COORD_W-1:0] u,
		input logic [COORD_W-1:0] v, output int a[4], output longint fx, output longint fy);
		int w;
		int h;
		int x0, x1, y0, y1;
		w = clamp_size(width_reg, MAX_WIDTH);
		h = clamp_size(height_reg, MAX_HEIGHT);
		wrap_axis(u, w, x0, x1, fx);
		wrap_axis(v, h, y0, y1, fy);
		a[0] = (x0 + y0 * w) & 16'hFFFF;
		a[1] = (x1 + y0 * w) & 16'hFFFF;
		a[2] = (x0 + y1 * w) & 16'hFFFF;
		a[3] = (x1 + y1 * w) & 16'hFFFF;
	endfunction

	function automatic rgb_t filter_sample(input logic [COORD_W-1:0] u,
		input logic [COORD_W-1:0] v);
		rgb_t res;
		int a[4];
		longint fx, fy;
		res = '{r: '0, g: '0, b: '0};
		if (!present_reg) return res;
		texel_addrs(u, v, a, fx, fy);
		res.r = blend_channel(texels[a[0]].r, texels[a[1]].r, texels[a[2]].r,
			texels[a[3]].r, fx, fy);
		res.g = blend_channel(texels[a[0]].g, texels[a[1]].g, texels[a[2]].g,
			texels[a[3]].g, fx, fy);
		res.b = blend_channel(texels[a[0]].b, texels[a[1]].b, texels[a[2]].b,
			texels[a[3]].b, fx, fy);
		return res;
	endfunction

	// send one request; called and returns at a falling edge, valid left high
	task automatic send_request(input logic cmd, input logic [COORD_W-1:0] u,
		input logic [COORD_W-1:0] v, input logic [TEXEL_AW-1:0] idx, input texel_t t);
		while ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.cmd <= cmd;
		in_ch.u_coord <= u;
		in_ch.v_coord <= v;
		in_ch.texel_index <= idx;
		in_ch.load_red <= t.r;
		in_ch.load_green <= t.g;
		in_ch.load_blue <= t.b;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		if (cmd == CMD_LOAD) begin
			texels[idx] = t;
			written[idx] = 1'b1;
			loads_sent++;
		end else begin
			pending_samples.push_back(filter_sample(u, v));
			samples_sent++;
		end
		@(negedge clk);
	endtask

	task automatic load_texel(input logic [TEXEL_AW-1:0] idx, input texel_t t);
		send_request(CMD_LOAD, '0, '0, idx, t);
	endtask

	function automatic texel_t rand_texel();
		texel_t t;
		case ($urandom_range(5))
			0: t = '{r: 16'h0000, g: 16'h0000, b: 16'h0000};
			1: t = '{r: 16'hFFFF, g: 16'hFFFF, b: 16'hFFFF};
			default: t = '{r: CH_W'($urandom), g: CH_W'($urandom), b: CH_W'($urandom)};
		endcase
		return t;
	endfunction

	// sample, loading first any texel it would read that was never written
	task automatic sample_at(input logic [COORD_W-1:0] u, input logic [COORD_W-1:0] v);
		int a[4];
		longint fx, fy;
		texel_addrs(u, v, a, fx, fy);
		foreach (a[k])
			if (!written[a[k]]) load_texel(TEXEL_AW'(a[k]), rand_texel());
		send_request(CMD_SAMPLE, u, v, TEXEL_AW'($urandom), rand_texel());
	endtask

	function automatic logic [COORD_W-1:0] rand_coord();
		logic [COORD_W-1:0] c;
		c = $urandom;
		case ($urandom_range(4))
			0: c[15:0] = 16'h0000;
			1: c[15:0] = 16'hFFFF;
			2: c[15:0] = 16'($urandom_range(16'h0600));
			3: c[15:0] = 16'h8000 + 16'($urandom_range(16'h00FF));
			default: ;
		endcase
		return c;
	endfunction

	// stop sending and wait for every expected result, then let the block settle
	task automatic drain();
		in_ch.valid <= 1'b0;
		while (pending_samples.size() != 0) @(negedge clk);
		repeat (SETTLE_TICKS) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SIZE_W-1:0] data);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= data;
		@(negedge clk);
		wr_en <= 1'b0;
		@(negedge clk);
		case (idx)
			REG_IMAGE_WIDTH: width_reg = data;
			REG_IMAGE_HEIGHT: height_reg = data;
			REG_TEXTURE_PRESENT: present_reg = data[0];
			default: ;
		endcase
	endtask

	task automatic set_image(input int w, input int h, input logic present);
		drain();
		write_reg(REG_IMAGE_WIDTH, SIZE_W'(w));
		write_reg(REG_IMAGE_HEIGHT, SIZE_W'(h));
		write_reg(REG_TEXTURE_PRESENT, SIZE_W'(present));
		settings_used++;
	endtask

	// no texture bound: every sample is zero, loads still land
	task automatic test_no_texture();
		load_texel(16'h0000, '{r: 16'hFFFF, g: 16'h1234, b: 16'h8000});
		sample_at(32'h0000_0000, 32'h0000_0000);
		sample_at(32'h7FFF_FFFF, 32'h8000_0000);
		sample_at(rand_coord(), rand_coord());
	endtask

	// extremes of coordinates, store indexes, channels and sizes
	task automatic test_directed();
		set_image(256, 256, 1'b1);
		load_texel(16'hFFFF, '{r: 16'hFFFF, g: 16'hFFFF, b: 16'hFFFF});
		load_texel(16'h0000, '{r: 16'hFFFF, g: 16'h0000, b: 16'hFFFF});
		load_texel(16'h0001, '{r: 16'h0000, g: 16'hFFFF, b: 16'h0000});
		// low edge: extrapolation past texel 0 both ways
		sample_at(32'h0000_0000, 32'h0000_0000);
		sample_at(32'h8000_0000, 32'h7FFF_0000);
		sample_at(32'h7FFF_FFFF, 32'hFFFF_FFFF);
		sample_at(32'h0000_8000, 32'h8000_8000);
		sample_at(32'h0000_0080, 32'h0000_0080);
		// clamped neighbor at the high edge
		sample_at(32'h0000_FFFF, 32'h0000_FFFF);
		// width 0 taken as 1, oversize taken as the maximum
		set_image(0, 511, 1'b1);
		sample_at(32'h1234_5678, 32'h0000_FFFF);
		sample_at(32'h0000_0000, 32'hFFFF_0000);
		set_image(511, 0, 1'b1);
		sample_at(32'h0000_FFFF, 32'h0000_7FFF);
		sample_at(32'hABCD_4000, 32'h0000_0000);
		set_image(1, 1, 1'b1);
		sample_at(32'h0000_8000, 32'h0000_8000);
		sample_at(32'h0000_0001, 32'h0000_FFFE);
	endtask

	// result side held off while requests keep coming; then a full pause
	task automatic test_backpressure();
		set_image(5, 3, 1'b1);
		hold_left = 400;
		repeat (60) sample_at(rand_coord(), rand_coord());
		drain();
	endtask

	task automatic test_random(input int count);
		for (int k = 0; k < count; k++) begin
			if ($urandom_range(99) < 15)
				load_texel(TEXEL_AW'($urandom), rand_texel());
			else
				sample_at(rand_coord(), rand_coord());
			// occasional re-load of a texel in use
			if ($urandom_range(99) < 5)
				load_texel(TEXEL_AW'($urandom_range(width_reg)), rand_texel());
		end
	endtask

	task automatic test_random_settings();
		int ws[12] = '{1, 2, 3, 0, 7, 1, 256, 511, 16, 0, 0, 0};
		int hs[12] = '{1, 2, 5, 0, 1, 9, 256, 300, 16, 0, 0, 0};
		for (int m = 0; m < 3; m++) begin
			case (m)
				0: begin send_idle_pct = 12; recv_idle_pct = 85; end
				1: begin send_idle_pct = 85; recv_idle_pct = 12; end
				default: begin send_idle_pct = 0; recv_idle_pct = 0; end
			endcase
			for (int s = 0; s < 4; s++) begin
				int j;
				int w;
				int h;
				j = m * 4 + s;
				w = (j >= 9) ? $urandom_range(1, 40) : ws[j];
				h = (j >= 9) ? $urandom_range(1, 40) : hs[j];
				set_image(w, h, (j == 8) ? 1'b0 : 1'b1);
				test_random(85);
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		wr_en = 1'b0;
		wr_index = '0;
		wr_data = '0;
		in_ch.valid = 1'b0;
		in_ch.cmd = CMD_SAMPLE;
		in_ch.u_coord = '0;
		in_ch.v_coord = '0;
		in_ch.texel_index = '0;
		in_ch.load_red = '0;
		in_ch.load_green = '0;
		in_ch.load_blue = '0;
		out_ch.ready = 1'b0;
		width_reg = SIZE_W'(1);
		height_reg = SIZE_W'(1);
		present_reg = 1'b0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_left = 0;
		cycles = 0;
		mismatches = 0;
		samples_sent = 0;
		loads_sent = 0;
		results_seen = 0;
		settings_used = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_no_texture();
		test_directed();
		test_backpressure();
		test_random_settings();
		drain();

		$display("Covered %0d samples and %0d texel loads over %0d image settings,",
			samples_sent, loads_sent, settings_used);
		$display("with %0d results checked under sender, receiver and long stalls.",
			results_seen);
		if (mismatches == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
